>>> rtl/core/egc_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the encoder and button gesture classifier.
// No dependencies; imported by every module of the block.
package egc_pkg;

    localparam int TimeW   = 32;
    localparam int CountW  = 32;
    localparam int CfgW    = 16;
    localparam int FlagW   = 7;
    localparam int CfgIdxW = 2;

    // encoder movement that counts as a turn
    localparam logic signed [CountW-1:0] TURN_STEP = CountW'(3);
    localparam logic signed [CountW-1:0] TURN_STEP_NEG = -TURN_STEP;
    // press start value that blocks any later press flag
    localparam logic [TimeW-1:0] SENTINEL_TIME = '1;

    // flag bit positions
    localparam int FL_UP       = 0;
    localparam int FL_DOWN     = 1;
    localparam int FL_LEFT     = 2;
    localparam int FL_RIGHT    = 3;
    localparam int FL_SHORT    = 4;
    localparam int FL_LONG     = 5;
    localparam int FL_PRESSING = 6;
    localparam logic [FlagW-1:0] GESTURE_MASK = 7'h3F;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SAMPLE_PERIOD = 2'd0,
        REG_SHORT_PRESS   = 2'd1,
        REG_LONG_PRESS    = 2'd2,
        REG_PRESSED_LEVEL = 2'd3
    } cfg_idx_t;

    localparam logic [CfgW-1:0] SAMPLE_PERIOD_RST = 16'd1;
    localparam logic [CfgW-1:0] SHORT_PRESS_RST   = 16'd50;
    localparam logic [CfgW-1:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic            PRESSED_LEVEL_RST = 1'b0;

    typedef struct packed {
        logic [CfgW-1:0] sample_period_ms;
        logic [CfgW-1:0] short_press_ms;
        logic [CfgW-1:0] long_press_ms;
        logic            pressed_level;
    } cfg_t;

    typedef struct packed {
        op_t                      operation;
        logic [TimeW-1:0]         now_ms;
        logic signed [CountW-1:0] encoder_count;
        logic                     button_level;
    } item_t;

    typedef struct packed {
        logic [TimeW-1:0]  last_eval_time;
        logic [CountW-1:0] last_count;
        logic              button_was_pressed;
        logic [TimeW-1:0]  press_start_time;
        logic [FlagW-1:0]  flags;
    } state_t;

endpackage

>>> rtl/core/encoder_button_gesture_classifier.sv
`timescale 1ns / 1ps
// Encoder and push-button gesture classifier: an input register, one pass of
// classification logic that updates the gesture state, and a result register.
// Takes one request per cycle unless a result is waiting on m_ready; a request
// passes the input register, then its result the result register. State is read
// and rewritten for each request. Each request returns one result with all flags.
module encoder_button_gesture_classifier
    import egc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [CfgW-1:0]          cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [TimeW-1:0]         s_now_ms,
    input  logic signed [CountW-1:0] s_encoder_count,
    input  logic                     s_button_level,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_flag_up,
    output logic                     m_flag_down,
    output logic                     m_flag_left,
    output logic                     m_flag_right,
    output logic                     m_flag_short,
    output logic                     m_flag_long,
    output logic                     m_pressing,
    output logic                     m_any_changed
);

    cfg_t             cfg_reg;
    item_t            item_reg;
    logic             item_valid_reg;
    state_t           state_reg;
    state_t           state_next;
    logic [FlagW-1:0] out_flags_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_period_ms <= SAMPLE_PERIOD_RST;
            cfg_reg.short_press_ms   <= SHORT_PRESS_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.pressed_level    <= PRESSED_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SAMPLE_PERIOD: cfg_reg.sample_period_ms <= cfg_wr_data;
                REG_SHORT_PRESS:   cfg_reg.short_press_ms   <= cfg_wr_data;
                REG_LONG_PRESS:    cfg_reg.long_press_ms    <= cfg_wr_data;
                REG_PRESSED_LEVEL: cfg_reg.pressed_level    <= cfg_wr_data[0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.operation     <= op_t'(s_operation);
            item_reg.now_ms        <= s_now_ms;
            item_reg.encoder_count <= s_encoder_count;
            item_reg.button_level  <= s_button_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    egc_classify u_classify (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_flags_reg <= state_next.flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_flag_up     = out_flags_reg[FL_UP];
    assign m_flag_down   = out_flags_reg[FL_DOWN];
    assign m_flag_left   = out_flags_reg[FL_LEFT];
    assign m_flag_right  = out_flags_reg[FL_RIGHT];
    assign m_flag_short  = out_flags_reg[FL_SHORT];
    assign m_flag_long   = out_flags_reg[FL_LONG];
    assign m_pressing    = out_flags_reg[FL_PRESSING];
    assign m_any_changed = |out_flags_reg;

endmodule

>>> rtl/core/egc_classify.sv
`timescale 1ns / 1ps
// Single-pass gesture classification: next state from one item and the current state.
// Depends on egc_pkg.
module egc_classify
    import egc_pkg::*;
(
    input  item_t  item,
    input  cfg_t   cfg,
    input  state_t state_cur,
    output state_t state_next
);

    logic [TimeW-1:0]         since_eval;
    logic                     due;
    logic signed [CountW-1:0] diff;
    logic                     rise;
    logic                     fall;
    logic                     pressed;
    logic [TimeW-1:0]         hold;
    logic                     hold_long;
    logic                     hold_short;

    always_comb begin
        since_eval = item.now_ms - state_cur.last_eval_time;
        due        = since_eval >= {{(TimeW-CfgW){1'b0}}, cfg.sample_period_ms};
        diff       = $signed(item.encoder_count - $signed(state_cur.last_count));
        rise       = diff >= TURN_STEP;
        fall       = diff <= TURN_STEP_NEG;
        pressed    = item.button_level == cfg.pressed_level;
        hold       = item.now_ms - state_cur.press_start_time;
        hold_long  = hold >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms};
        hold_short = hold >= {{(TimeW-CfgW){1'b0}}, cfg.short_press_ms};

        state_next = state_cur;
        if (item.operation == OP_CLEAR) begin
            state_next.flags = state_cur.flags & ~GESTURE_MASK;
        end else if (due) begin
            state_next.last_eval_time = item.now_ms;
            if (rise || fall) begin
                if (pressed) begin
                    if (rise) state_next.flags[FL_DOWN] = 1'b1;
                    else      state_next.flags[FL_UP]   = 1'b1;
                    state_next.button_was_pressed = 1'b1;
                    state_next.press_start_time   = SENTINEL_TIME;
                end else begin
                    if (rise) state_next.flags[FL_LEFT]  = 1'b1;
                    else      state_next.flags[FL_RIGHT] = 1'b1;
                end
                state_next.last_count = item.encoder_count;
            end else begin
                if (pressed && !state_cur.button_was_pressed) begin
                    state_next.press_start_time   = item.now_ms;
                    state_next.flags[FL_PRESSING] = 1'b1;
                end else if (pressed) begin
                    if (item.now_ms > state_cur.press_start_time && hold_long) begin
                        state_next.flags[FL_LONG]   = 1'b1;
                        state_next.press_start_time = SENTINEL_TIME;
                    end
                end else if (state_cur.button_was_pressed) begin
                    // suppressed press, or time wrapped during the hold
                    if (state_cur.press_start_time > item.now_ms) begin
                        state_next.press_start_time = item.now_ms;
                    end else if (hold_long) begin
                        state_next.flags[FL_LONG] = 1'b1;
                    end else if (hold_short) begin
                        state_next.flags[FL_SHORT] = 1'b1;
                    end
                    state_next.flags[FL_PRESSING] = 1'b0;
                end
                state_next.button_was_pressed = pressed;
            end
        end
    end

endmodule
